// File: design/rsgf_pkg.sv
// Shared types and constants for the range scan gap finder.
// Used by rsgf_tracker, rsgf_result_fifo and range_scan_gap_finder_core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsgf_pkg;

  localparam int IDX_W       = 10;
  localparam int THR_W       = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int FIFO_DEPTH  = 4;

  localparam int SCAN_SIZE_DEF  = 1024;
  localparam int RANGE_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_DISTANCE = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [THR_W-1:0] RST_FREE_THRESHOLD = 16'hFFFF;
  localparam logic [IDX_W-1:0] RST_WINDOW_START   = 10'd0;
  localparam logic [IDX_W-1:0] RST_WINDOW_END     = 10'd1023;
  localparam logic [IDX_W-1:0] RST_MERGE_DISTANCE = 10'd3;

  typedef struct packed {
    logic [THR_W-1:0] free_threshold;
    logic [IDX_W-1:0] window_start;
    logic [IDX_W-1:0] window_end;
    logic [IDX_W-1:0] merge_distance;
  } rsgf_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] gap_start;
    logic [IDX_W-1:0] gap_end;
    logic             gap_valid;
    logic             scan_done;
  } rsgf_res_t;

  // Results caused by one item: an emitted pending gap first, then the flush.
  typedef struct packed {
    logic      emit_vld;
    rsgf_res_t emit_res;
    logic      flush_vld;
    rsgf_res_t flush_res;
  } rsgf_push_t;

endpackage

`default_nettype wire

// File: design/rsgf_tracker.sv
// Per-sample gap tracking: window test, gap open/close, merge and flush.
// Depends on rsgf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsgf_tracker
  import rsgf_pkg::*;
#(
  parameter int SCAN_SIZE  = SCAN_SIZE_DEF,
  parameter int RANGE_BITS = RANGE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rsgf_cfg_t             cfg,
  input  wire logic                  acc,
  input  wire logic [RANGE_BITS-1:0] range_sample,
  input  wire logic                  sample_invalid,
  input  wire logic                  scan_last,
  output rsgf_push_t                 push
);

  localparam int CMP_W = (RANGE_BITS > THR_W) ? RANGE_BITS : THR_W;
  localparam logic [16:0] LAST_IDX = 17'(SCAN_SIZE - 1);

  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             flushed_r, flushed_nxt;
  logic             open_r, open_nxt;
  logic [IDX_W-1:0] open_start_r, open_start_nxt;
  logic             pv_r, pv_nxt;
  logic [IDX_W-1:0] ps_r, ps_nxt;
  logic [IDX_W-1:0] pe_r, pe_nxt;

  logic [IDX_W-1:0] wend;
  logic             in_win, is_free, do_open, do_close_win, at_end, do_close;
  logic [IDX_W-1:0] close_s, close_e;
  logic [IDX_W:0]   gap_dist;
  logic             merge;
  logic             pv_c;
  logic [IDX_W-1:0] ps_c, pe_c;

  always_comb begin
    wend = ({7'b0, cfg.window_end} > LAST_IDX) ? LAST_IDX[IDX_W-1:0] : cfg.window_end;
    in_win = (cnt_r >= cfg.window_start) && (cnt_r <= wend);
    is_free = sample_invalid ||
              (CMP_W'(range_sample) >= CMP_W'(cfg.free_threshold));
    do_open      = in_win && !open_r && is_free;
    do_close_win = in_win && open_r && (!is_free || sample_invalid);
    at_end       = (cnt_r == wend) || scan_last;
    // An open gap closes on the window end, including one that opened here.
    do_close = do_close_win || (at_end && (open_r || do_open));
    close_s  = do_open ? cnt_r : open_start_r;
    close_e  = do_close_win ? (cnt_r - 1'b1) : cnt_r;

    gap_dist = {1'b0, close_s} - {1'b0, pe_r};
    merge    = pv_r && ($signed(gap_dist) <= $signed({1'b0, cfg.merge_distance}));

    pv_c = pv_r;
    ps_c = ps_r;
    pe_c = pe_r;
    push.emit_vld  = 1'b0;
    push.emit_res  = '{gap_start: ps_r, gap_end: pe_r, gap_valid: 1'b1, scan_done: 1'b0};
    if (do_close) begin
      if (merge) begin
        pe_c = close_e;
      end else begin
        push.emit_vld = pv_r;
        pv_c = 1'b1;
        ps_c = close_s;
        pe_c = close_e;
      end
    end

    push.flush_vld = at_end;
    if (pv_c) begin
      push.flush_res = '{gap_start: ps_c, gap_end: pe_c, gap_valid: 1'b1, scan_done: 1'b1};
    end else begin
      push.flush_res = '{gap_start: '0, gap_end: '0, gap_valid: 1'b0, scan_done: 1'b1};
    end

    // Nothing is pushed once the scan has been flushed or without an item.
    if (!acc || flushed_r) begin
      push.emit_vld  = 1'b0;
      push.flush_vld = 1'b0;
    end

    cnt_nxt        = cnt_r;
    flushed_nxt    = flushed_r;
    open_nxt       = open_r;
    open_start_nxt = open_start_r;
    pv_nxt         = pv_r;
    ps_nxt         = ps_r;
    pe_nxt         = pe_r;
    if (acc) begin
      if (!flushed_r) begin
        open_nxt = (open_r || do_open) && !do_close;
        if (do_open) begin
          open_start_nxt = cnt_r;
        end
        pv_nxt = pv_c && !at_end;
        ps_nxt = ps_c;
        pe_nxt = pe_c;
        flushed_nxt = at_end;
      end
      if (scan_last) begin
        cnt_nxt     = '0;
        flushed_nxt = 1'b0;
        open_nxt    = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      flushed_r    <= 1'b0;
      open_r       <= 1'b0;
      open_start_r <= '0;
      pv_r         <= 1'b0;
      ps_r         <= '0;
      pe_r         <= '0;
    end else begin
      cnt_r        <= cnt_nxt;
      flushed_r    <= flushed_nxt;
      open_r       <= open_nxt;
      open_start_r <= open_start_nxt;
      pv_r         <= pv_nxt;
      ps_r         <= ps_nxt;
      pe_r         <= pe_nxt;
    end
  end

  // A flushed scan holds neither an open nor a pending gap.
  a_flushed_clean: assert property (@(posedge clk) disable iff (!rst_n)
    flushed_r |-> (!pv_r && !open_r))
    else $error("flushed scan still holds gap state");

  // The last sample of a scan restarts the index count.
  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && scan_last) |=> (cnt_r == '0 && !flushed_r))
    else $error("scan end did not restart the index");

  // Every scan_last that finds the scan unflushed produces the final result.
  a_last_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && scan_last && !flushed_r) |-> push.flush_vld)
    else $error("scan end without final result");

endmodule

`default_nettype wire

// File: design/rsgf_result_fifo.sv
// Small result queue taking up to two results per cycle and giving one while the output is ready.
// Depends on rsgf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsgf_result_fifo
  import rsgf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire rsgf_push_t push,
  output logic            space_ok,
  output logic            out_vld,
  output rsgf_res_t       out_res,
  input  wire logic       out_rdy
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  rsgf_res_t        mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] wr_a, wr_b;
  logic             pop;

  always_comb begin
    out_vld  = (count_r != '0);
    pop      = out_vld && out_rdy;
    out_res  = mem[rd_ptr_r];
    space_ok = (count_r <= CNT_W'(FIFO_DEPTH - 2));
    wr_a     = wr_ptr_r;
    wr_b     = wr_ptr_r + PTR_W'(push.emit_vld);
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.emit_vld) + PTR_W'(push.flush_vld);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push.emit_vld) + CNT_W'(push.flush_vld) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.emit_vld) begin
      mem[wr_a] <= push.emit_res;
    end
    if (push.flush_vld) begin
      mem[wr_b] <= push.flush_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.emit_vld || push.flush_vld) |-> space_ok)
    else $error("result pushed without room");

  a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == PTR_W'(count_r))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: design/range_scan_gap_finder_core.sv
// Top level of the range scan gap finder: configuration registers, the gap
// tracker and the result queue. Depends on rsgf_pkg, rsgf_tracker, rsgf_result_fifo.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake             Content
// in_       in   in_tvalid/in_tready   range sample, invalid flag, last of scan
// out_      out  out_tvalid/out_tready gap start/end, gap valid flag, scan done
// cfg_      in   cfg_we                register index and write data
//
// Each item is processed in the cycle it is accepted, so one item can be
// taken every cycle. An item causes zero, one or two result items; they go
// into a four-entry result queue that drains one item per cycle while the
// output is ready, and a result is offered at the earliest in the cycle after
// its item was taken. The input is ready while the queue has room for two
// results. With the output always ready the queue never holds more than two
// results, so the input never stalls; when the output stalls, the input is
// held once three results wait, until the receiver takes one.
// Reset is synchronous and active low; it clears all tracking state and
// returns the configuration registers to their defaults.

module range_scan_gap_finder_core
  import rsgf_pkg::*;
#(
  parameter int SCAN_SIZE  = SCAN_SIZE_DEF,
  parameter int RANGE_BITS = RANGE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input item stream.
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [((RANGE_BITS+7)/8)*8-1:0]  in_tdata,  // range_sample, zero pad
  input  wire logic                             in_tuser,  // sample_invalid
  input  wire logic                             in_tlast,  // scan_last
  // Result item stream.
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [23:0]                           out_tdata, // gap_start, gap_end, zero pad
  output logic                                  out_tuser, // gap_valid
  output logic                                  out_tlast, // scan_done
  // Configuration write port.
  input  wire logic                             cfg_we,
  input  wire logic [CFG_IDX_W-1:0]             cfg_index,
  input  wire logic [CFG_DATA_W-1:0]            cfg_data
);

  rsgf_cfg_t  cfg_r, cfg_nxt;
  rsgf_push_t push;
  rsgf_res_t  res;
  logic       space_ok;
  logic       in_acc;

  // Register writes; the index covers exactly the four registers.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FREE_THRESHOLD: cfg_nxt.free_threshold = cfg_data[THR_W-1:0];
        CFG_WINDOW_START:   cfg_nxt.window_start   = cfg_data[IDX_W-1:0];
        CFG_WINDOW_END:     cfg_nxt.window_end     = cfg_data[IDX_W-1:0];
        CFG_MERGE_DISTANCE: cfg_nxt.merge_distance = cfg_data[IDX_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.free_threshold <= RST_FREE_THRESHOLD;
      cfg_r.window_start   <= RST_WINDOW_START;
      cfg_r.window_end     <= RST_WINDOW_END;
      cfg_r.merge_distance <= RST_MERGE_DISTANCE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = space_ok;
  assign in_acc    = in_tvalid && space_ok;

  rsgf_tracker #(
    .SCAN_SIZE  (SCAN_SIZE),
    .RANGE_BITS (RANGE_BITS)
  ) u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .acc            (in_acc),
    .range_sample   (in_tdata[RANGE_BITS-1:0]),
    .sample_invalid (in_tuser),
    .scan_last      (in_tlast),
    .push           (push)
  );

  rsgf_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_vld  (out_tvalid),
    .out_res  (res),
    .out_rdy  (out_tready)
  );

  // Results are packed with the gap start in the lowest bits.
  assign out_tdata = {4'b0, res.gap_end, res.gap_start};
  assign out_tuser = res.gap_valid;
  assign out_tlast = res.scan_done;

endmodule

`default_nettype wire
